/* hw/rtl/hxc_pkg.sv */
`timescale 1ns / 1ps
// hxc_pkg: shared types, constants and helper functions for the world_to_hex_cell block.
// No dependencies; every other file in hw/rtl refers to it by scoped names.

package hxc_pkg;

  // Output cell coordinate width (signed)
  localparam int GRID_BITS = 16;
  // Default fixed-point fraction width of world coordinates and tile reciprocal
  localparam int FRAC_BITS_DEFAULT = 16;
  // Entries in the front-to-back queue
  localparam int QUEUE_DEPTH = 2;

  // round(sqrt(3) * 2^30)
  localparam logic [31:0] SQRT3_Q30 = 32'd1859775393;
  // inv_tile_size after reset: 1.0 in Q16.16
  localparam logic [31:0] INV_TILE_RESET = 32'd65536;

  // Input transaction payload
  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_z;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [GRID_BITS-1:0] grid_col;
    logic signed [GRID_BITS-1:0] grid_row;
    logic                        saturated;
  } out_t;

  // Classified point handed from the front end to the back end
  typedef struct packed {
    logic        neg_x;
    logic        neg_z;
    logic [31:0] mag_x;
    logic [31:0] mag_z;
  } front_rec_t;

  // One radix-16 long-division step by 3: {rem, digit} / 3.
  // Returns {quotient digit[3:0], remainder[1:0]}. t <= 47, so t*43 >> 7 is exact.
  function automatic logic [5:0] div3_step(input logic [1:0] rem, input logic [3:0] digit);
    logic [5:0]  t;
    logic [10:0] p;
    logic [3:0]  q;
    logic [5:0]  r;
    t = {rem, digit};
    p = 11'(t) * 11'd43;
    q = p[10:7];
    r = t - 6'(q) - 6'({q, 1'b0});
    return {q, r[1:0]};
  endfunction

endpackage

/* hw/rtl/hxc_front.sv */
`timescale 1ns / 1ps
// hxc_front: accepts input transactions and splits each coordinate into sign and magnitude.
// Depends on hxc_pkg (in_t, front_rec_t); feeds hxc_queue.

module hxc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hxc_pkg::in_t       in_data,
  input  logic               q_full,
  output logic               push,
  output hxc_pkg::front_rec_t rec
);

  logic                vld_r;
  logic                vld_nxt;
  logic                accept;
  hxc_pkg::front_rec_t rec_r;
  hxc_pkg::front_rec_t rec_nxt;

  // handshake: hold a record until the queue takes it
  assign busy    = vld_r & q_full;
  assign accept  = start & ~busy;
  assign push    = vld_r & ~q_full;
  assign vld_nxt = accept | (vld_r & ~push);

  // sign / magnitude split; -2^31 has magnitude 2^31, which fits 32 unsigned bits
  always_comb begin
    rec_nxt.neg_x = in_data.world_x[31];
    rec_nxt.neg_z = in_data.world_z[31];
    rec_nxt.mag_x = in_data.world_x[31] ? 32'(-in_data.world_x) : 32'(in_data.world_x);
    rec_nxt.mag_z = in_data.world_z[31] ? 32'(-in_data.world_z) : 32'(in_data.world_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec = rec_r;

endmodule

/* hw/rtl/hxc_queue.sv */
`timescale 1ns / 1ps
// hxc_queue: short FIFO of classified points between the front and back ends.
// Depends on hxc_pkg (front_rec_t).

module hxc_queue #(
  parameter int DEPTH = hxc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hxc_pkg::front_rec_t din,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output hxc_pkg::front_rec_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hxc_pkg::front_rec_t mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r;
  logic [PW-1:0]       rd_ptr_nxt;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop & not_empty;
  assign dout      = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* hw/rtl/hxc_round3.sv */
`timescale 1ns / 1ps
// hxc_round3: pipelined division by 3 of three unsigned lanes, four radix-16 digits per stage.
// Depends on hxc_pkg (div3_step); a sideband word travels alongside with matching latency.

module hxc_round3 #(
  parameter int UW  = 21,
  parameter int SBW = 51
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [2:0][UW-1:0]  in_u,
  input  logic [SBW-1:0]      in_sb,
  output logic                out_vld,
  output logic [2:0][UW-1:0]  out_q,
  output logic [2:0][1:0]     out_rem,
  output logic [SBW-1:0]      out_sb
);

  localparam int NS = (UW + 15) / 16;  // pipeline stages
  localparam int ND = NS * 4;          // radix-16 digits, zero padded
  localparam int XW = ND * 4;

  // each stage's vector holds quotient digits above the cursor, dividend digits below
  logic [2:0][XW-1:0] x_r   [NS+1];
  logic [2:0][1:0]    rem_r [NS+1];
  logic [SBW-1:0]     sb_r  [NS+1];
  logic               vld_r [NS+1];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      x_r[0][l]   <= XW'(in_u[l]);
      rem_r[0][l] <= 2'b00;
    end
    sb_r[0] <= in_sb;
  end

  // long-division stages, most significant digit first
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [2:0][XW-1:0] x_nxt;
    logic [2:0][1:0]    rem_nxt;

    always_comb begin
      logic [5:0] qr;
      x_nxt   = x_r[s];
      rem_nxt = rem_r[s];
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < 4; j++) begin
          qr = hxc_pkg::div3_step(rem_nxt[l], x_nxt[l][(ND - 1 - s * 4 - j) * 4 +: 4]);
          x_nxt[l][(ND - 1 - s * 4 - j) * 4 +: 4] = qr[5:2];
          rem_nxt[l] = qr[1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      x_r[s+1]   <= x_nxt;
      rem_r[s+1] <= rem_nxt;
      sb_r[s+1]  <= sb_r[s];
    end
  end

  assign out_vld = vld_r[NS];
  assign out_sb  = sb_r[NS];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_q[l]   = x_r[NS][l][UW-1:0];
      out_rem[l] = rem_r[NS][l];
    end
  end

endmodule

/* hw/rtl/hxc_back.sv */
`timescale 1ns / 1ps
// hxc_back: scaling, axial conversion, cube rounding, rebuild, offset conversion and saturation.
// Depends on hxc_pkg and hxc_round3; takes one classified point per cycle, never stalls.

module hxc_back #(
  parameter int FRAC_BITS = hxc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         inv_tile_size,
  input  logic                rec_vld,
  input  hxc_pkg::front_rec_t rec,
  output logic                out_strobe,
  output hxc_pkg::out_t       out_data
);

  localparam int F   = FRAC_BITS;
  localparam int G   = hxc_pkg::GRID_BITS;
  localparam int AW  = G + F + 3;      // clamped scaled magnitude
  localparam int ZW  = AW + 1;         // sqrt(3)-scaled z magnitude
  localparam int VW  = AW + 2;         // signed tripled axial values
  localparam int MW  = AW + 1;         // their magnitudes
  localparam int UW  = MW + 1 - F;     // rounding dividend after the fraction shift
  localparam int EW  = F + 2;          // rounding error
  localparam int NW  = UW + 1;         // signed rounded coordinate
  localparam int RW  = UW + 3;         // col / row before saturation
  localparam int SBW = 3 + 3 * F;

  localparam logic [AW-1:0]        CLAMP_LIM = {1'b1, {(AW - 1){1'b0}}};
  localparam logic [MW:0]          HALF_D    = (MW + 1)'(3) << (F - 1);
  localparam logic [EW-1:0]        HALF_D_E  = EW'(3) << (F - 1);
  localparam logic signed [RW-1:0] G_HI      = RW'((64'sd1 <<< (G - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] G_LO      = -G_HI - RW'(1);

  // S1: magnitude times reciprocal tile size
  logic        v1_r;
  logic        nx1_r, nz1_r;
  logic [63:0] px1_r, pz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= rec_vld;
  end

  always_ff @(posedge clk) begin
    nx1_r <= rec.neg_x;
    nz1_r <= rec.neg_z;
    px1_r <= {32'b0, rec.mag_x} * {32'b0, inv_tile_size};
    pz1_r <= {32'b0, rec.mag_z} * {32'b0, inv_tile_size};
  end

  // S2: drop the fraction and pre-clamp
  logic          v2_r;
  logic          nx2_r, nz2_r;
  logic [AW-1:0] ax2_r, az2_r;
  logic [AW-1:0] ax_nxt, az_nxt;
  logic [63:0]   sx_sh, sz_sh;

  always_comb begin
    sx_sh  = px1_r >> F;
    sz_sh  = pz1_r >> F;
    ax_nxt = (sx_sh > 64'(CLAMP_LIM)) ? CLAMP_LIM : sx_sh[AW-1:0];
    az_nxt = (sz_sh > 64'(CLAMP_LIM)) ? CLAMP_LIM : sz_sh[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    nx2_r <= nx1_r;
    nz2_r <= nz1_r;
    ax2_r <= ax_nxt;
    az2_r <= az_nxt;
  end

  // S3: z magnitude times sqrt(3), split in high and low 32-bit halves
  logic          v3_r;
  logic          nx3_r, nz3_r;
  logic [AW-1:0] ax3_r;
  logic [63:0]   hz3_r, lz3_r;
  logic [63:0]   az64;

  assign az64 = 64'(az2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    nx3_r <= nx2_r;
    nz3_r <= nz2_r;
    ax3_r <= ax2_r;
    hz3_r <= {32'b0, az64[63:32]} * {32'b0, hxc_pkg::SQRT3_Q30};
    lz3_r <= {32'b0, az64[31:0]} * {32'b0, hxc_pkg::SQRT3_Q30};
  end

  // S4: combine partial products, apply signs
  logic                 v4_r;
  logic signed [VW-1:0] sx4_r, sz4_r;
  logic [63:0]          pz_sum;
  logic signed [VW-1:0] axs, azs;

  always_comb begin
    pz_sum = (hz3_r << 2) + (lz3_r >> 30);
    axs    = $signed(VW'(ax3_r));
    azs    = $signed(VW'(pz_sum[ZW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    sx4_r <= nx3_r ? -axs : axs;
    sz4_r <= nz3_r ? -azs : azs;
  end

  // S5: tripled axial coordinates q, y, r
  logic                 v5_r;
  logic signed [VW-1:0] q3_r, y3_r, r3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    q3_r <= sx4_r <<< 1;
    y3_r <= -sx4_r - sz4_r;
    r3_r <= sz4_r - sx4_r;
  end

  // S6: magnitude plus half a step; lanes are q, y, r
  logic signed [VW-1:0]     v3_lane [3];
  logic [2:0][UW-1:0]       rd_u;
  logic [SBW-1:0]           rd_sb;
  logic [2:0]               lane_neg;
  logic [2:0][F-1:0]        lane_low;

  assign v3_lane[0] = q3_r;
  assign v3_lane[1] = y3_r;
  assign v3_lane[2] = r3_r;

  always_comb begin
    logic signed [VW-1:0] mabs;
    logic [MW:0]          t;
    for (int l = 0; l < 3; l++) begin
      lane_neg[l] = v3_lane[l][VW-1];
      mabs        = lane_neg[l] ? -v3_lane[l] : v3_lane[l];
      t           = (MW + 1)'(mabs[MW-1:0]) + HALF_D;
      rd_u[l]     = t[MW:F];
      lane_low[l] = t[F-1:0];
    end
    rd_sb = {lane_neg, lane_low};
  end

  // divide by 3 across stages
  logic               rd_vld;
  logic [2:0][UW-1:0] rd_q;
  logic [2:0][1:0]    rd_rem;
  logic [SBW-1:0]     rd_sb_o;

  hxc_round3 #(
    .UW  (UW),
    .SBW (SBW)
  ) u_round3 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v5_r),
    .in_u    (rd_u),
    .in_sb   (rd_sb),
    .out_vld (rd_vld),
    .out_q   (rd_q),
    .out_rem (rd_rem),
    .out_sb  (rd_sb_o)
  );

  // S7: rounding error |D/2 - (t mod D)| and signed rounded values
  logic                 v7_r;
  logic [EW-1:0]        err7_r [3];
  logic signed [NW-1:0] n7_r   [3];
  logic [2:0]           o_neg;
  logic [2:0][F-1:0]    o_low;

  assign {o_neg, o_low} = rd_sb_o;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= rd_vld;
  end

  always_ff @(posedge clk) begin
    logic [EW-1:0]        w;
    logic signed [NW-1:0] ns;
    for (int l = 0; l < 3; l++) begin
      w         = {rd_rem[l], o_low[l]};
      ns        = $signed({1'b0, rd_q[l]});
      err7_r[l] <= (w > HALF_D_E) ? (w - HALF_D_E) : (HALF_D_E - w);
      n7_r[l]   <= o_neg[l] ? -ns : ns;
    end
  end

  // S8: rebuild the coordinate with the largest error
  logic                 v8_r;
  logic signed [RW-1:0] col8_r, rr8_r;
  logic signed [RW-1:0] col_nxt, rr_nxt;
  logic signed [RW-1:0] rqx, ryx, rrx;

  always_comb begin
    rqx = RW'(n7_r[0]);
    ryx = RW'(n7_r[1]);
    rrx = RW'(n7_r[2]);
    col_nxt = rqx;
    rr_nxt  = rrx;
    if ((err7_r[0] > err7_r[1]) && (err7_r[0] > err7_r[2])) begin
      col_nxt = -ryx - rrx;
    end else if (err7_r[1] > err7_r[2]) begin
      col_nxt = rqx;  // y rebuilt, not needed
    end else begin
      rr_nxt = -rqx - ryx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= v7_r;
  end

  always_ff @(posedge clk) begin
    col8_r <= col_nxt;
    rr8_r  <= rr_nxt;
  end

  // S9: odd-q row, saturation, output register
  logic                 strobe_r;
  hxc_pkg::out_t        out_r;
  hxc_pkg::out_t        out_nxt;
  logic signed [RW-1:0] row;
  logic signed [RW-1:0] col_c, row_c;
  logic                 sat;

  always_comb begin
    row   = rr8_r + (col8_r >>> 1);
    sat   = 1'b0;
    col_c = col8_r;
    row_c = row;
    if (col8_r > G_HI) begin
      col_c = G_HI;
      sat   = 1'b1;
    end else if (col8_r < G_LO) begin
      col_c = G_LO;
      sat   = 1'b1;
    end
    if (row > G_HI) begin
      row_c = G_HI;
      sat   = 1'b1;
    end else if (row < G_LO) begin
      row_c = G_LO;
      sat   = 1'b1;
    end
    out_nxt.grid_col  = col_c[G-1:0];
    out_nxt.grid_row  = row_c[G-1:0];
    out_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

/* hw/rtl/world_to_hex_cell.sv */
`timescale 1ns / 1ps
// world_to_hex_cell: maps a world point (x, z, signed Q.FRAC_BITS) to the flat-top hex cell
// holding it, in odd-q offset coordinates, saturated to GRID_BITS. One transaction is taken per
// clock (start while busy is low) and every one yields exactly one result, in order, shown for a
// single cycle with out_strobe; the receiver cannot stall, so busy stays low in steady use. The
// divide-by-3 pipeline that rounds the cube coordinates has NS = ceil((GRID_BITS + 5) / 16) stages.
// inv_tile_size (cfg_data, unsigned Q.FRAC_BITS) is written over the cfg channel, which is always
// ready; write it only while no transaction is in flight. Depends on hxc_pkg, hxc_front, hxc_queue
// and hxc_back.

module world_to_hex_cell #(
  parameter int FRAC_BITS   = hxc_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = hxc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hxc_pkg::in_t  in_data,
  output logic          out_strobe,
  output hxc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  logic [31:0]         inv_tile_r;
  logic                push;
  logic                q_full;
  logic                q_vld;
  hxc_pkg::front_rec_t front_rec;
  hxc_pkg::front_rec_t back_rec;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_tile_r <= hxc_pkg::INV_TILE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      inv_tile_r <= cfg_data;
    end
  end

  hxc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (push),
    .rec     (front_rec)
  );

  // back end drains one record per cycle
  hxc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (front_rec),
    .full      (q_full),
    .pop       (q_vld),
    .not_empty (q_vld),
    .dout      (back_rec)
  );

  hxc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .inv_tile_size (inv_tile_r),
    .rec_vld       (q_vld),
    .rec           (back_rec),
    .out_strobe    (out_strobe),
    .out_data      (out_data)
  );

endmodule
